/* sv/assert_macros.svh */
// Assertion macros used by the walker top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");
`define ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition seen");
`else
`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_NEVER(label, clk, rst, cond)
`endif
`endif

/* sv/sv39ptw_pkg.sv */
// Types, codes and constants of the Sv39 page table walker
package sv39ptw_pkg;

   localparam int TABLES_DEF = 8;
   localparam int ENTRIES    = 512;
   localparam int IDX_W      = 9;
   localparam int TBL_NUM_W  = 8;
   localparam int TBL_FLD_W  = 3;
   localparam int PTE_W      = 64;
   localparam int VA_W       = 39;
   localparam int PPN_W      = 44;
   localparam int PPN_LSB    = 10;
   localparam int ST_W       = 3;
   localparam int CMD_W      = 2;

   localparam logic [CMD_W-1:0] CMD_WRITE  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd1;
   localparam logic [CMD_W-1:0] CMD_UNMAP  = 2'd2;

   localparam logic [ST_W-1:0] ST_NONE  = 3'd0;
   localparam logic [ST_W-1:0] ST_4K    = 3'd1;
   localparam logic [ST_W-1:0] ST_2M    = 3'd2;
   localparam logic [ST_W-1:0] ST_1G    = 3'd3;
   localparam logic [ST_W-1:0] ST_BAD   = 3'd4;
   localparam logic [ST_W-1:0] ST_WROTE = 3'd5;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_START,
      S_READ,
      S_CHECK,
      S_FIN
   } state_type;

   typedef enum logic [1:0] {
      RES_NONE,
      RES_WROTE,
      RES_BAD,
      RES_LEAF
   } res_kind_type;

   typedef struct packed {
      logic [CMD_W-1:0]     command;
      logic [TBL_FLD_W-1:0] table_number;
      logic [IDX_W-1:0]     entry_index;
      logic [PTE_W-1:0]     entry_value;
      logic [VA_W-1:0]      virtual_address;
   } req_type;

   typedef struct packed {
      logic [ST_W-1:0]      status;
      logic [TBL_FLD_W-1:0] found_table;
      logic [IDX_W-1:0]     found_slot;
      logic [PTE_W-1:0]     found_entry;
   } rsp_type;

   typedef struct packed {
      logic         item_load;
      logic         clr_en;
      logic         rd_en;
      logic         descend;
      logic         wr_item;
      logic         wr_zero;
      logic         res_load;
      res_kind_type res_kind;
      logic         out_load;
   } ctl_type;

   typedef struct packed {
      logic             clr_last;
      logic [CMD_W-1:0] cmd;
      logic             tn_ok;
      logic             tbl_ok;
      logic             pte_v;
      logic             pte_leaf;
      logic             ppn_ok;
      logic             out_free;
   } sts_type;

endpackage

/* sv/sv39ptw_ram.sv */
// Generic single write port, single read port RAM with registered read data
module sv39ptw_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

/* sv/sv39ptw_ctrl.sv */
// Walk controller: clearing sweep, command sequencing and result handoff
module sv39ptw_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  sv39ptw_pkg::sts_type sts,
   output sv39ptw_pkg::ctl_type ctl
);

   sv39ptw_pkg::state_type state_ff;
   sv39ptw_pkg::state_type state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sv39ptw_pkg::S_CLEAR: begin
            if (sts.clr_last) begin
               state_in = sv39ptw_pkg::S_IDLE;
            end
         end
         sv39ptw_pkg::S_IDLE: begin
            if (req_valid) begin
               state_in = sv39ptw_pkg::S_START;
            end
         end
         sv39ptw_pkg::S_START: begin
            unique case (sts.cmd)
               sv39ptw_pkg::CMD_LOOKUP, sv39ptw_pkg::CMD_UNMAP: begin
                  state_in = sts.tbl_ok ? sv39ptw_pkg::S_CHECK : sv39ptw_pkg::S_FIN;
               end
               default: begin
                  state_in = sv39ptw_pkg::S_FIN;
               end
            endcase
         end
         sv39ptw_pkg::S_READ: begin
            state_in = sv39ptw_pkg::S_CHECK;
         end
         sv39ptw_pkg::S_CHECK: begin
            if (sts.pte_v && !sts.pte_leaf && sts.ppn_ok) begin
               state_in = sv39ptw_pkg::S_READ;
            end else begin
               state_in = sv39ptw_pkg::S_FIN;
            end
         end
         sv39ptw_pkg::S_FIN: begin
            if (sts.out_free) begin
               state_in = sv39ptw_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = sv39ptw_pkg::S_CLEAR;
         end
      endcase
   end

   always_comb begin
      ctl          = '0;
      ctl.res_kind = sv39ptw_pkg::RES_NONE;
      req_ready    = 1'b0;
      unique case (state_ff)
         sv39ptw_pkg::S_CLEAR: begin
            ctl.clr_en = 1'b1;
         end
         sv39ptw_pkg::S_IDLE: begin
            req_ready     = 1'b1;
            ctl.item_load = req_valid;
         end
         sv39ptw_pkg::S_START: begin
            unique case (sts.cmd)
               sv39ptw_pkg::CMD_WRITE: begin
                  ctl.wr_item  = sts.tn_ok;
                  ctl.res_load = 1'b1;
                  ctl.res_kind = sts.tn_ok ? sv39ptw_pkg::RES_WROTE : sv39ptw_pkg::RES_BAD;
               end
               sv39ptw_pkg::CMD_LOOKUP, sv39ptw_pkg::CMD_UNMAP: begin
                  ctl.rd_en    = sts.tbl_ok;
                  ctl.res_load = !sts.tbl_ok;
                  ctl.res_kind = sv39ptw_pkg::RES_BAD;
               end
               default: begin
                  ctl.res_load = 1'b1;
                  ctl.res_kind = sv39ptw_pkg::RES_NONE;
               end
            endcase
         end
         sv39ptw_pkg::S_READ: begin
            ctl.rd_en = 1'b1;
         end
         sv39ptw_pkg::S_CHECK: begin
            priority if (!sts.pte_v) begin
               ctl.res_load = 1'b1;
               ctl.res_kind = sv39ptw_pkg::RES_NONE;
            end else if (sts.pte_leaf) begin
               ctl.res_load = 1'b1;
               ctl.res_kind = sv39ptw_pkg::RES_LEAF;
               ctl.wr_zero  = (sts.cmd == sv39ptw_pkg::CMD_UNMAP);
            end else if (!sts.ppn_ok) begin
               ctl.res_load = 1'b1;
               ctl.res_kind = sv39ptw_pkg::RES_BAD;
            end else begin
               ctl.descend = 1'b1;
            end
         end
         sv39ptw_pkg::S_FIN: begin
            ctl.out_load = sts.out_free;
         end
         default: begin
            ctl.clr_en = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sv39ptw_pkg::S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* sv/sv39ptw_dpath.sv */
// Walk datapath: entry memory, walk registers, result and output registers
module sv39ptw_dpath #(
   parameter int TABLES = sv39ptw_pkg::TABLES_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_valid,
   input  logic [sv39ptw_pkg::TBL_FLD_W-1:0]     csr_root_table,
   input  sv39ptw_pkg::req_type                  req_data,
   input  logic                                  rsp_ready,
   output logic                                  rsp_valid,
   output sv39ptw_pkg::rsp_type                  rsp_data,
   input  sv39ptw_pkg::ctl_type                  ctl,
   output sv39ptw_pkg::sts_type                  sts
);

   localparam int DEPTH   = TABLES * sv39ptw_pkg::ENTRIES;
   localparam int ADDR_W  = $clog2(DEPTH);
   localparam int FULL_W  = sv39ptw_pkg::TBL_NUM_W + sv39ptw_pkg::IDX_W;
   localparam int CMP_W   = sv39ptw_pkg::TBL_NUM_W + 1;
   localparam int PAD_W   = sv39ptw_pkg::TBL_NUM_W - sv39ptw_pkg::TBL_FLD_W;

   logic [sv39ptw_pkg::TBL_FLD_W-1:0] root_ff, root_in;
   sv39ptw_pkg::req_type              item_ff, item_in;
   logic [sv39ptw_pkg::TBL_NUM_W-1:0] table_ff, table_in;
   logic [1:0]                        level_ff, level_in;
   logic [ADDR_W-1:0]                 clr_cnt_ff, clr_cnt_in;
   sv39ptw_pkg::rsp_type              res_ff, res_in;
   sv39ptw_pkg::rsp_type              rsp_ff, rsp_in;
   logic                              rsp_valid_ff, rsp_valid_in;

   logic [sv39ptw_pkg::IDX_W-1:0]     walk_idx;
   logic [ADDR_W-1:0]                 walk_addr;
   logic [ADDR_W-1:0]                 item_addr;
   logic [sv39ptw_pkg::PTE_W-1:0]     pte;
   logic [sv39ptw_pkg::PPN_W-1:0]     ppn;
   logic [sv39ptw_pkg::ST_W-1:0]      leaf_status;
   logic                              mem_we;
   logic [ADDR_W-1:0]                 mem_waddr;
   logic [sv39ptw_pkg::PTE_W-1:0]     mem_wdata;

   always_comb begin
      unique case (level_ff)
         2'd2:    walk_idx = item_ff.virtual_address[38:30];
         2'd1:    walk_idx = item_ff.virtual_address[29:21];
         2'd0:    walk_idx = item_ff.virtual_address[20:12];
         default: walk_idx = '0;
      endcase
   end

   always_comb begin
      unique case (level_ff)
         2'd2:    leaf_status = sv39ptw_pkg::ST_1G;
         2'd1:    leaf_status = sv39ptw_pkg::ST_2M;
         default: leaf_status = sv39ptw_pkg::ST_4K;
      endcase
   end

   assign walk_addr = ADDR_W'(FULL_W'({table_ff, walk_idx}));
   assign item_addr = ADDR_W'(FULL_W'({{PAD_W{1'b0}}, item_ff.table_number,
                                        item_ff.entry_index}));
   assign ppn       = pte[sv39ptw_pkg::PPN_LSB +: sv39ptw_pkg::PPN_W];

   always_comb begin
      mem_we = ctl.clr_en || ctl.wr_item || ctl.wr_zero;
      priority if (ctl.clr_en) begin
         mem_waddr = clr_cnt_ff;
         mem_wdata = '0;
      end else if (ctl.wr_item) begin
         mem_waddr = item_addr;
         mem_wdata = item_ff.entry_value;
      end else begin
         mem_waddr = walk_addr;
         mem_wdata = '0;
      end
   end

   sv39ptw_ram #(
      .WIDTH (sv39ptw_pkg::PTE_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .re    (ctl.rd_en),
      .raddr (walk_addr),
      .rdata (pte)
   );

   always_comb begin
      root_in      = csr_valid ? csr_root_table : root_ff;
      item_in      = ctl.item_load ? req_data : item_ff;
      table_in     = table_ff;
      level_in     = level_ff;
      clr_cnt_in   = ctl.clr_en ? clr_cnt_ff + 1'b1 : clr_cnt_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;

      if (ctl.item_load) begin
         table_in = {{PAD_W{1'b0}}, root_ff};
         level_in = 2'd2;
      end else if (ctl.descend) begin
         table_in = ppn[sv39ptw_pkg::TBL_NUM_W-1:0];
         level_in = level_ff - 2'd1;
      end

      if (ctl.res_load) begin
         res_in = '0;
         unique case (ctl.res_kind)
            sv39ptw_pkg::RES_NONE:  res_in.status = sv39ptw_pkg::ST_NONE;
            sv39ptw_pkg::RES_WROTE: res_in.status = sv39ptw_pkg::ST_WROTE;
            sv39ptw_pkg::RES_BAD:   res_in.status = sv39ptw_pkg::ST_BAD;
            sv39ptw_pkg::RES_LEAF: begin
               res_in.status      = leaf_status;
               res_in.found_table = table_ff[sv39ptw_pkg::TBL_FLD_W-1:0];
               res_in.found_slot  = walk_idx;
               res_in.found_entry = pte;
            end
            default: res_in.status = sv39ptw_pkg::ST_NONE;
         endcase
      end

      if (ctl.out_load) begin
         rsp_in       = res_ff;
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         root_ff      <= '0;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         root_ff      <= root_in;
         clr_cnt_ff   <= clr_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff  <= item_in;
      table_ff <= table_in;
      level_ff <= level_in;
      res_ff   <= res_in;
      rsp_ff   <= rsp_in;
   end

   always_comb begin
      sts.clr_last = (clr_cnt_ff == ADDR_W'(DEPTH - 1));
      sts.cmd      = item_ff.command;
      sts.tn_ok    = ({{(CMP_W - sv39ptw_pkg::TBL_FLD_W){1'b0}}, item_ff.table_number}
                      < CMP_W'(TABLES));
      sts.tbl_ok   = ({1'b0, table_ff} < CMP_W'(TABLES));
      sts.pte_v    = pte[0];
      sts.pte_leaf = (level_ff == 2'd0) || (|pte[3:1]);
      sts.ppn_ok   = (ppn < sv39ptw_pkg::PPN_W'(TABLES));
      sts.out_free = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

/* sv/sv39_page_table_walker_unit.sv */
// Writes, unused commands and bad root tables end in START; lookups and unmaps read one
// entry per level (START or READ, then CHECK) until a leaf, an invalid entry or a bad
// table. One item at a time: the next accept follows the result through FIN, so the wait
// grows with the chain of dependent reads on the single read port of the entry memory;
// a finished result holds in place while the previous word still waits at rsp. Reset: a
// sweep zeroes all TABLES*512 entries, req_ready low meanwhile; root_table to 0, csr open.
`include "assert_macros.svh"

module sv39_page_table_walker_unit #(
   parameter int TABLES = sv39ptw_pkg::TABLES_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  sv39ptw_pkg::req_type              req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output sv39ptw_pkg::rsp_type              rsp_data,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [sv39ptw_pkg::TBL_FLD_W-1:0] csr_root_table
);

   sv39ptw_pkg::ctl_type ctl;
   sv39ptw_pkg::sts_type sts;

   assign csr_ready = 1'b1;

   sv39ptw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .ctl       (ctl)
   );

   sv39ptw_dpath #(
      .TABLES (TABLES)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .csr_valid      (csr_valid),
      .csr_root_table (csr_root_table),
      .req_data       (req_data),
      .rsp_ready      (rsp_ready),
      .rsp_valid      (rsp_valid),
      .rsp_data       (rsp_data),
      .ctl            (ctl),
      .sts            (sts)
   );

   `ASSERT_NEVER(a_rd_during_wr, clock, reset, ctl.rd_en && (ctl.clr_en || ctl.wr_item || ctl.wr_zero))
   `ASSERT_IMPLY(a_clear_blocks_req, clock, reset, ctl.clr_en, !req_ready)
   `ASSERT_IMPLY(a_load_into_free, clock, reset, ctl.out_load, sts.out_free)
   `ASSERT_IMPLY(a_zero_only_unmap, clock, reset, ctl.wr_zero, sts.cmd == sv39ptw_pkg::CMD_UNMAP)

endmodule

/* tb/sv39_walk_checker.sv */
// Scoreboard for the Sv39 walker: predicts each result and compares it field by field
`timescale 1ns / 100ps

module sv39_walk_checker
   import sv39ptw_pkg::*;
#(
   parameter int TABLES = TABLES_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_ready,
   input  req_type              req_data,
   input  logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  rsp_type              rsp_data,
   input  logic                 csr_valid,
   input  logic                 csr_ready,
   input  logic [TBL_FLD_W-1:0] csr_root_table,
   output int                   mismatch_count,
   output int                   pending_count
);

   localparam int PAGE_SHIFT = 12;

   logic [PTE_W-1:0]     pte_mem [TABLES*ENTRIES];
   logic [TBL_FLD_W-1:0] root_sel;
   rsp_type              pending_results [$];

   function automatic rsp_type translate_command(req_type w);
      rsp_type          r;
      int unsigned      tbl;
      int               lvl;
      logic [IDX_W-1:0] idx;
      logic [PTE_W-1:0] pte;
      logic [PPN_W-1:0] ppn;
      bit               done;
      r = '0;
      case (w.command)
         CMD_WRITE: begin
            if (w.table_number < TABLES) begin
               pte_mem[w.table_number*ENTRIES + w.entry_index] = w.entry_value;
               r.status = ST_WROTE;
            end else begin
               r.status = ST_BAD;
            end
         end
         CMD_LOOKUP, CMD_UNMAP: begin
            tbl = root_sel;
            lvl = 2;
            done = 1'b0;
            while (!done) begin
               if (tbl >= TABLES) begin
                  r.status = ST_BAD;
                  done = 1'b1;
               end else begin
                  idx = w.virtual_address[PAGE_SHIFT + IDX_W*lvl +: IDX_W];
                  pte = pte_mem[tbl*ENTRIES + idx];
                  if (!pte[0]) begin
                     r.status = ST_NONE;
                     done = 1'b1;
                  end else if (lvl == 0 || pte[3:1] != 3'b000) begin
                     r.status = (lvl == 2) ? ST_1G : (lvl == 1) ? ST_2M : ST_4K;
                     r.found_table = TBL_FLD_W'(tbl);
                     r.found_slot = idx;
                     r.found_entry = pte;
                     if (w.command == CMD_UNMAP)
                        pte_mem[tbl*ENTRIES + idx] = '0;
                     done = 1'b1;
                  end else begin
                     ppn = pte[PPN_LSB +: PPN_W];
                     if (ppn >= TABLES)
                        tbl = TABLES;
                     else
                        tbl = int'(ppn);
                     lvl--;
                  end
               end
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      int      bad;
      if (reset) begin
         foreach (pte_mem[i])
            pte_mem[i] = '0;
         root_sel = '0;
         pending_results.delete();
         mismatch_count <= 0;
         pending_count <= 0;
      end else begin
         bad = 0;
         if (csr_valid && csr_ready)
            root_sel = csr_root_table;
         if (req_valid && req_ready)
            pending_results.push_back(translate_command(req_data));
         if (rsp_valid && rsp_ready) begin
            if (pending_results.size() == 0) begin
               bad++;
               $display("%0t: unexpected word: expected none, got %h", $time, rsp_data);
            end else begin
               want = pending_results.pop_front();
               if (rsp_data.status !== want.status) begin
                  bad++;
                  $display("%0t: status expected %0d, got %0d",
                           $time, want.status, rsp_data.status);
               end
               if (rsp_data.found_table !== want.found_table) begin
                  bad++;
                  $display("%0t: found_table expected %0d, got %0d",
                           $time, want.found_table, rsp_data.found_table);
               end
               if (rsp_data.found_slot !== want.found_slot) begin
                  bad++;
                  $display("%0t: found_slot expected %0d, got %0d",
                           $time, want.found_slot, rsp_data.found_slot);
               end
               if (rsp_data.found_entry !== want.found_entry) begin
                  bad++;
                  $display("%0t: found_entry expected %h, got %h",
                           $time, want.found_entry, rsp_data.found_entry);
               end
            end
         end
         mismatch_count <= mismatch_count + bad;
         pending_count <= pending_results.size();
      end
   end

endmodule

/* tb/tb_sv39_page_table_walker_unit.sv */
// Testbench top for the Sv39 walker: stimulus, handshake pacing, watchdog and verdict
`timescale 1ns / 100ps

module tb_sv39_page_table_walker_unit;
   import sv39ptw_pkg::*;

   localparam int               TABLES      = TABLES_DEF;
   localparam logic [CMD_W-1:0] CMD_UNUSED  = 2'd3;
   localparam int               ITEM_TARGET = 1100;
   localparam int               PHASES      = 6;
   localparam int               STALL_LIMIT = 20000;
   localparam int               TAIL_CYCLES = 20;
   localparam int               PAGE_SHIFT  = 12;
   localparam int               MAX_WAIT    = 17;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   req_type              req_data;
   logic                 rsp_valid;
   logic                 rsp_ready;
   rsp_type              rsp_data;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [TBL_FLD_W-1:0] csr_root_table;
   int                   mismatch_count;
   int                   pending_count;

   int                   items_sent;
   int                   req_calm;
   int                   rsp_calm;
   int                   idle_cycles;
   logic [TBL_FLD_W-1:0] cur_root;
   logic [38:0]          va_top;

   sv39_page_table_walker_unit #(.TABLES(TABLES)) dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_root_table (csr_root_table)
   );

   sv39_walk_checker #(.TABLES(TABLES)) walk_chk (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_root_table (csr_root_table),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic int draw_wait(inout int calm);
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 40) == 0)
         calm = $urandom_range(15, 40);
      return $urandom_range(0, MAX_WAIT);
   endfunction

   function automatic req_type fill_random();
      req_type     w;
      logic [63:0] a;
      logic [63:0] b;
      a = rand64();
      b = rand64();
      w.command = a[1:0];
      w.table_number = a[4:2];
      w.entry_index = a[13:5];
      w.entry_value = rand64();
      w.virtual_address = b[38:0];
      return w;
   endfunction

   function automatic logic [63:0] pointer_entry(logic [PPN_W-1:0] ppn);
      logic [63:0] v;
      v = rand64();
      v[PPN_LSB +: PPN_W] = ppn;
      v[3:0] = 4'b0001;
      return v;
   endfunction

   function automatic logic [63:0] leaf_entry(bit last_level);
      logic [63:0] v;
      v = rand64();
      v[0] = 1'b1;
      if (last_level) begin
         if ($urandom_range(0, 1) == 0)
            v[3:1] = 3'b000;
      end else if (v[3:1] == 3'b000) begin
         v[3:1] = 3'($urandom_range(1, 7));
      end
      return v;
   endfunction

   function automatic logic [PPN_W-1:0] pick_table();
      logic [63:0]      r;
      logic [PPN_W-1:0] p;
      if ($urandom_range(0, 9) == 0) begin
         r = rand64();
         p = r[PPN_W-1:0];
         if (p < TABLES)
            p[PPN_W-1] = 1'b1;
      end else begin
         p = PPN_W'($urandom_range(0, TABLES-1));
      end
      return p;
   endfunction

   task automatic drain_results();
      req_valid <= 1'b0;
      do
         @(posedge clock);
      while (pending_count != 0);
   endtask

   task automatic send_word(input req_type w);
      int gap;
      gap = draw_wait(req_calm);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= w;
      @(posedge clock);
      while (!(req_valid && req_ready)) @(posedge clock);
      items_sent++;
      if ($urandom_range(0, 59) == 0)
         drain_results();
   endtask

   task automatic put_entry(input logic [TBL_FLD_W-1:0] tn, input logic [IDX_W-1:0] idx,
                            input logic [63:0] val);
      req_type w;
      w = fill_random();
      w.command = CMD_WRITE;
      w.table_number = tn;
      w.entry_index = idx;
      w.entry_value = val;
      send_word(w);
   endtask

   task automatic put_walk(input logic [CMD_W-1:0] cmd, input logic [38:0] va);
      req_type w;
      w = fill_random();
      w.command = cmd;
      w.virtual_address = va;
      send_word(w);
   endtask

   task automatic write_root(input logic [TBL_FLD_W-1:0] v);
      drain_results();
      csr_valid <= 1'b1;
      csr_root_table <= v;
      @(posedge clock);
      while (!(csr_valid && csr_ready)) @(posedge clock);
      csr_valid <= 1'b0;
      cur_root = v;
   endtask

   task automatic walk_scenario();
      logic [63:0]      r;
      logic [63:0]      pte;
      logic [38:0]      va;
      logic [PPN_W-1:0] next_tbl;
      int               tbl;
      int               lvl;
      int               leaf_lvl;
      bit               stop;
      r = rand64();
      va = r[38:0];
      leaf_lvl = $urandom_range(0, 2);
      tbl = cur_root;
      next_tbl = '0;
      stop = 1'b0;
      for (lvl = 2; lvl >= leaf_lvl && !stop; lvl--) begin
         if (lvl == leaf_lvl) begin
            pte = leaf_entry(lvl == 0);
         end else begin
            next_tbl = pick_table();
            pte = pointer_entry(next_tbl);
            if (next_tbl >= TABLES)
               stop = 1'b1;
         end
         if ($urandom_range(0, 11) == 0) begin
            pte[0] = 1'b0;
            stop = 1'b1;
         end
         put_entry(TBL_FLD_W'(tbl), va[PAGE_SHIFT + IDX_W*lvl +: IDX_W], pte);
         tbl = int'(next_tbl[15:0]);
      end
      put_walk(CMD_LOOKUP, va);
      case ($urandom_range(0, 3))
         0: begin
            put_walk(CMD_UNMAP, va);
            put_walk(CMD_LOOKUP, va);
         end
         1: put_walk(CMD_UNMAP, va);
         2: begin
            r = rand64();
            va[PAGE_SHIFT +: IDX_W] = r[IDX_W-1:0];
            put_walk(CMD_LOOKUP, va);
         end
         default: ;
      endcase
   endtask

   task automatic noise_item();
      req_type w;
      w = fill_random();
      case ($urandom_range(0, 7))
         0, 1, 2: w.command = CMD_WRITE;
         3, 4:    w.command = CMD_LOOKUP;
         5, 6:    w.command = CMD_UNMAP;
         default: w.command = CMD_UNUSED;
      endcase
      send_word(w);
   endtask

   initial begin
      rsp_ready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         int stall;
         stall = draw_wait(rsp_calm);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!(rsp_valid && rsp_ready)) @(posedge clock);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles == STALL_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   initial begin
      int phase;
      int phase_end;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_root_table = '0;
      items_sent = 0;
      req_calm = 0;
      rsp_calm = 0;
      idle_cycles = 0;
      cur_root = '0;
      va_top = '1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      write_root(3'd0);
      put_walk(CMD_LOOKUP, '0);
      put_entry(3'd0, 9'd0, '1);
      put_walk(CMD_LOOKUP, 39'h0_0000_0abc);
      put_walk(CMD_UNMAP, '0);
      put_walk(CMD_LOOKUP, '0);
      put_entry(3'd0, 9'd511, pointer_entry(44'd5));
      put_entry(3'd5, 9'd511, pointer_entry(44'd6));
      put_entry(3'd6, 9'd511, 64'h1);
      put_walk(CMD_LOOKUP, va_top);
      put_entry(3'd6, 9'd511, ~64'h1);
      put_walk(CMD_LOOKUP, va_top);
      put_entry(3'd5, 9'd511, 64'h5);
      put_walk(CMD_UNMAP, va_top);
      put_entry(3'd5, 9'd511, pointer_entry('1));
      put_walk(CMD_LOOKUP, va_top);
      put_entry(3'd0, 9'd511, pointer_entry(PPN_W'(TABLES)));
      put_walk(CMD_UNMAP, va_top);
      put_entry(3'd7, 9'd0, '0);
      put_walk(CMD_UNUSED, va_top);
      write_root(3'd7);
      put_entry(3'd7, 9'd511, 64'hf);
      put_walk(CMD_LOOKUP, va_top);

      for (phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: write_root(3'd7);
            1: write_root(3'd3);
            2: write_root(3'd0);
            3: write_root(3'd5);
            default: write_root(3'($urandom_range(0, 7)));
         endcase
         phase_end = items_sent + ITEM_TARGET / PHASES;
         while (items_sent < phase_end) begin
            if ($urandom_range(0, 3) == 0)
               noise_item();
            else
               walk_scenario();
         end
      end

      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

/* filelist.f */
+incdir+sv
sv/sv39ptw_pkg.sv
sv/sv39ptw_ram.sv
sv/sv39ptw_ctrl.sv
sv/sv39ptw_dpath.sv
sv/sv39_page_table_walker_unit.sv
tb/sv39_walk_checker.sv
tb/tb_sv39_page_table_walker_unit.sv
